[hw/rtl/two_pool_rotating_slot_allocator_macros.svh]
// Assertion macros shared by the slot allocator RTL.
`ifndef TWO_POOL_ROTATING_SLOT_ALLOCATOR_MACROS_SVH
`define TWO_POOL_ROTATING_SLOT_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is active
`define TPRSA_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("allocator same-cycle check failed");
// Next-cycle implication, disabled while reset is active
`define TPRSA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("allocator next-cycle check failed");
`else
`define TPRSA_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define TPRSA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

[hw/rtl/tprsa_pkg.sv]
// Types and constants shared by the slot allocator modules.
package tprsa_pkg;

    localparam int WANT_W     = 24;
    localparam int SLOT_W     = 6;
    localparam int CNT_REG_W  = 7;
    localparam int TOTAL_W    = 8;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_FALLBACK  = 3'd1,
        ST_ZERO      = 3'd2,
        ST_RELEASED  = 3'd3,
        ST_NOT_OWNED = 3'd4,
        ST_TWICE     = 3'd5
    } status_t;

    localparam logic CMD_BORROW  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic POOL_SMALL = 1'b0;
    localparam logic POOL_LARGE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_READY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_SIZE  = 2'd3;

    localparam logic [WANT_W-1:0] SMALL_SIZE_RESET = 24'd4096;

    // Request transaction
    typedef struct packed {
        logic              command;
        logic [WANT_W-1:0] wanted_bytes;
        logic              release_pool;
        logic [SLOT_W-1:0] release_slot;
    } req_t;

    // Response transaction
    typedef struct packed {
        status_t            status;
        logic               granted_pool;
        logic [SLOT_W-1:0]  granted_slot;
        logic [TOTAL_W-1:0] slots_in_use;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    idle;
        logic    load_req;
        logic    do_release;
        logic    set_status;
        status_t status;
        logic    origin_direct;
        logic    mod_load;
        logic    mod_step;
        logic    scan;
        logic    commit;
        logic    try_next;
        logic    out_load;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_release;
        logic is_zero;
        logic pool_ready;
        logic pool_empty;
        logic start_ge;
        logic mod_last;
        logic found;
        logic try_last;
        logic out_free;
    } ctl_sts_t;

endpackage

[hw/rtl/tprsa_ctrl.sv]
// Sequencing state machine of the slot allocator.
module tprsa_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  tprsa_pkg::ctl_sts_t sts,
    output tprsa_pkg::ctl_cmd_t cmd
);
    import tprsa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PICK = 6'b000010,
        S_MOD  = 6'b000100,
        S_SCAN = 6'b001000,
        S_SEL  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        cmd        = '0;
        cmd.status = ST_GRANTED;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_PICK;
                end
            end
            S_PICK:
            begin
                if (sts.is_release)
                begin
                    cmd.do_release = 1'b1;
                    state_next     = S_OUT;
                end
                else if (sts.is_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_ZERO;
                    state_next     = S_OUT;
                end
                else if (!sts.pool_ready)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FALLBACK;
                    state_next     = S_OUT;
                end
                else if (sts.pool_empty)
                begin
                    // empty pool: skip it without touching its start
                    if (sts.try_last)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_FALLBACK;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        cmd.try_next = 1'b1;
                    end
                end
                else if (sts.start_ge)
                begin
                    cmd.mod_load = 1'b1;
                    state_next   = S_MOD;
                end
                else
                begin
                    cmd.origin_direct = 1'b1;
                    state_next        = S_SCAN;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                cmd.commit = 1'b1;
                if (sts.found)
                begin
                    state_next = S_OUT;
                end
                else if (sts.try_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FALLBACK;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.try_next = 1'b1;
                    state_next   = S_PICK;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/tprsa_datapath.sv]
// Datapath of the slot allocator: config, busy bits, start pointers, search.
module tprsa_datapath
#(
    parameter int SMALL_DEPTH = 64,
    parameter int LARGE_DEPTH = 64
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tprsa_pkg::req_t                       req_data,
    input  logic                                  cfg_we,
    input  logic [tprsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tprsa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  rsp_stall,
    output logic                                  rsp_valid,
    output tprsa_pkg::rsp_t                       rsp_data,
    input  tprsa_pkg::ctl_cmd_t                   cmd,
    output tprsa_pkg::ctl_sts_t                   sts
);
    import tprsa_pkg::*;

    localparam int DMAX = (SMALL_DEPTH > LARGE_DEPTH) ? SMALL_DEPTH : LARGE_DEPTH;
    localparam int IW   = (DMAX > 1) ? $clog2(DMAX) : 1;
    localparam int CW   = $clog2(DMAX + 1);
    localparam int WW   = (CW > CNT_REG_W) ? CW : CNT_REG_W;
    localparam int NW   = (IW > 1) ? $clog2(IW) : 1;

    // Configuration registers
    logic                  pool_ready_reg;
    logic [CNT_REG_W-1:0]  small_cnt_reg;
    logic [CNT_REG_W-1:0]  large_cnt_reg;
    logic [WANT_W-1:0]     small_size_reg;

    // Allocator state
    logic [SMALL_DEPTH-1:0] small_busy_reg;
    logic [SMALL_DEPTH-1:0] small_busy_next;
    logic [LARGE_DEPTH-1:0] large_busy_reg;
    logic [LARGE_DEPTH-1:0] large_busy_next;
    logic [IW-1:0]          small_start_reg;
    logic [IW-1:0]          large_start_reg;
    logic [TOTAL_W-1:0]     total_reg;

    // Working registers of one transaction
    req_t                   req_reg;
    logic                   try_reg;
    logic [IW-1:0]          origin_reg;
    logic [CW-1:0]          rem_reg;
    logic [IW-1:0]          div_reg;
    logic [NW-1:0]          step_reg;
    logic [DMAX-1:0]        avail_reg;
    logic [DMAX-1:0]        hi_reg;
    status_t                res_status_reg;
    logic                   res_pool_reg;
    logic [SLOT_W-1:0]      res_slot_reg;

    // Output register
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;

    // Combinational helpers
    logic [CW-1:0]   small_live;
    logic [CW-1:0]   large_live;
    logic            fits;
    logic            cur_pool;
    logic [CW-1:0]   cur_count;
    logic [IW-1:0]   cur_start;
    logic [DMAX-1:0] cur_busy;
    logic [DMAX-1:0] avail_c;
    logic [DMAX-1:0] hi_c;
    logic [CW:0]     mod_trial;
    logic [CW:0]     mod_cnt_ext;
    logic [CW-1:0]   rem_new;
    logic [IW-1:0]   sel_idx;
    logic            found;
    logic [CW-1:0]   start_inc;
    logic [IW-1:0]   start_adv;
    logic            grant_set;
    logic [CW-1:0]   rel_count;
    logic            rel_out;
    logic            rel_busy;
    logic            rel_clear;

    // Lowest set bit of a vector
    function automatic logic [IW-1:0] first_set(input logic [DMAX-1:0] vec);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = DMAX - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = IW'(i);
            end
        end
        return idx;
    endfunction

    // Live slot counts, saturated at the pool depth
    assign small_live = (WW'(small_cnt_reg) > WW'(SMALL_DEPTH)) ? CW'(SMALL_DEPTH)
                                                               : CW'(small_cnt_reg);
    assign large_live = (WW'(large_cnt_reg) > WW'(LARGE_DEPTH)) ? CW'(LARGE_DEPTH)
                                                               : CW'(large_cnt_reg);

    // Pool of the current try: small first when the size fits, else large first
    assign fits      = req_reg.wanted_bytes <= small_size_reg;
    assign cur_pool  = fits ? try_reg : ~try_reg;
    assign cur_count = (cur_pool == POOL_LARGE) ? large_live : small_live;
    assign cur_start = (cur_pool == POOL_LARGE) ? large_start_reg : small_start_reg;

    // Busy view of the current pool, slots beyond the depth read busy
    for (genvar i = 0; i < DMAX; i++)
    begin : g_view
        logic s_bit;
        logic l_bit;
        if (i < SMALL_DEPTH)
        begin : g_s
            assign s_bit = small_busy_reg[i];
        end
        else
        begin : g_sn
            assign s_bit = 1'b1;
        end
        if (i < LARGE_DEPTH)
        begin : g_l
            assign l_bit = large_busy_reg[i];
        end
        else
        begin : g_ln
            assign l_bit = 1'b1;
        end
        assign cur_busy[i] = (cur_pool == POOL_LARGE) ? l_bit : s_bit;
        assign avail_c[i]  = !cur_busy[i] && (CW'(i) < cur_count);
        assign hi_c[i]     = avail_c[i] && (IW'(i) >= origin_reg);
    end

    // One restoring remainder step: start mod count, a bit per cycle
    assign mod_trial   = {rem_reg, div_reg[IW-1]};
    assign mod_cnt_ext = (CW + 1)'(cur_count);
    assign rem_new     = (mod_trial >= mod_cnt_ext) ? CW'(mod_trial - mod_cnt_ext)
                                                    : CW'(mod_trial);

    // Rotating pick: first free at or after origin, else first free overall
    assign found   = |avail_reg;
    assign sel_idx = (|hi_reg) ? first_set(hi_reg) : first_set(avail_reg);

    // Start advances past the origin, wrapping at the count
    assign start_inc = CW'(origin_reg) + CW'(1);
    assign start_adv = (start_inc == cur_count) ? '0 : IW'(start_inc);

    assign grant_set = cmd.commit && found;

    // Release checks
    assign rel_count = (req_reg.release_pool == POOL_LARGE) ? large_live : small_live;
    assign rel_out   = WW'(req_reg.release_slot) >= WW'(rel_count);

    always_comb
    begin
        rel_busy = 1'b0;
        for (int i = 0; i < SMALL_DEPTH; i++)
        begin
            if ((req_reg.release_pool == POOL_SMALL) &&
                (WW'(req_reg.release_slot) == WW'(i)))
            begin
                rel_busy = small_busy_reg[i];
            end
        end
        for (int i = 0; i < LARGE_DEPTH; i++)
        begin
            if ((req_reg.release_pool == POOL_LARGE) &&
                (WW'(req_reg.release_slot) == WW'(i)))
            begin
                rel_busy = large_busy_reg[i];
            end
        end
    end

    assign rel_clear = cmd.do_release && !rel_out && rel_busy;

    // Busy bit updates: set on grant, clear on a valid release
    always_comb
    begin
        small_busy_next = small_busy_reg;
        large_busy_next = large_busy_reg;
        for (int i = 0; i < SMALL_DEPTH; i++)
        begin
            if (grant_set && (cur_pool == POOL_SMALL) && (sel_idx == IW'(i)))
            begin
                small_busy_next[i] = 1'b1;
            end
            if (rel_clear && (req_reg.release_pool == POOL_SMALL) &&
                (WW'(req_reg.release_slot) == WW'(i)))
            begin
                small_busy_next[i] = 1'b0;
            end
        end
        for (int i = 0; i < LARGE_DEPTH; i++)
        begin
            if (grant_set && (cur_pool == POOL_LARGE) && (sel_idx == IW'(i)))
            begin
                large_busy_next[i] = 1'b1;
            end
            if (rel_clear && (req_reg.release_pool == POOL_LARGE) &&
                (WW'(req_reg.release_slot) == WW'(i)))
            begin
                large_busy_next[i] = 1'b0;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_ready_reg <= 1'b0;
            small_cnt_reg  <= '0;
            large_cnt_reg  <= '0;
            small_size_reg <= SMALL_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POOL_READY:  pool_ready_reg <= cfg_data[0];
                CFG_SMALL_COUNT: small_cnt_reg  <= cfg_data[CNT_REG_W-1:0];
                CFG_LARGE_COUNT: large_cnt_reg  <= cfg_data[CNT_REG_W-1:0];
                CFG_SMALL_SIZE:  small_size_reg <= cfg_data[WANT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Busy bits, start pointers, busy count, try index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_busy_reg  <= '0;
            large_busy_reg  <= '0;
            small_start_reg <= '0;
            large_start_reg <= '0;
            total_reg       <= '0;
            try_reg         <= 1'b0;
        end
        else
        begin
            small_busy_reg <= small_busy_next;
            large_busy_reg <= large_busy_next;
            if (cmd.commit)
            begin
                if (cur_pool == POOL_LARGE)
                begin
                    large_start_reg <= start_adv;
                end
                else
                begin
                    small_start_reg <= start_adv;
                end
            end
            if (grant_set)
            begin
                total_reg <= total_reg + TOTAL_W'(1);
            end
            else if (rel_clear)
            begin
                total_reg <= total_reg - TOTAL_W'(1);
            end
            if (cmd.load_req)
            begin
                try_reg <= 1'b0;
            end
            else if (cmd.try_next)
            begin
                try_reg <= 1'b1;
            end
        end
    end

    // Transaction working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_data;
        end
        if (cmd.origin_direct)
        begin
            origin_reg <= cur_start;
        end
        if (cmd.mod_load)
        begin
            rem_reg  <= '0;
            div_reg  <= cur_start;
            step_reg <= NW'(IW - 1);
        end
        else if (cmd.mod_step)
        begin
            rem_reg  <= rem_new;
            div_reg  <= div_reg << 1;
            step_reg <= step_reg - NW'(1);
            if (step_reg == '0)
            begin
                origin_reg <= IW'(rem_new);
            end
        end
        if (cmd.scan)
        begin
            avail_reg <= avail_c;
            hi_reg    <= hi_c;
        end
        // result fields; pool and slot stay zero without a grant
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
            res_pool_reg   <= 1'b0;
            res_slot_reg   <= '0;
        end
        else if (grant_set)
        begin
            res_status_reg <= ST_GRANTED;
            res_pool_reg   <= cur_pool;
            res_slot_reg   <= SLOT_W'(sel_idx);
        end
        else if (cmd.do_release)
        begin
            res_status_reg <= rel_out ? ST_NOT_OWNED : (rel_busy ? ST_RELEASED : ST_TWICE);
            res_pool_reg   <= 1'b0;
            res_slot_reg   <= '0;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Output register payload, busy count taken after the update
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.status       <= res_status_reg;
            rsp_reg.granted_pool <= res_pool_reg;
            rsp_reg.granted_slot <= res_slot_reg;
            rsp_reg.slots_in_use <= total_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Status to the controller
    assign sts.is_release = (req_reg.command == CMD_RELEASE);
    assign sts.is_zero    = (req_reg.wanted_bytes == '0);
    assign sts.pool_ready = pool_ready_reg;
    assign sts.pool_empty = (cur_count == '0);
    assign sts.start_ge   = (CW'(cur_start) >= cur_count);
    assign sts.mod_last   = (step_reg == '0);
    assign sts.found      = found;
    assign sts.try_last   = try_reg;
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

endmodule

[hw/rtl/two_pool_rotating_slot_allocator.sv]
// Top level of the two-pool rotating slot allocator: sequencer, datapath and checks.
// Release, zero-size and not-ready borrow: result set in the pick state, then output.
// Borrow: pick, scan, select and output states when the first pool serves it; a second
// try returns to pick, an empty pool skipped stays in pick, a start past a lowered count
// adds the mod state's remainder steps; a stalled result holds off the next transaction.
// Reset: async; busy bits, starts and busy count clear at once, config takes reset values.
`include "two_pool_rotating_slot_allocator_macros.svh"
module two_pool_rotating_slot_allocator
#(
    parameter int SMALL_DEPTH = 64,
    parameter int LARGE_DEPTH = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  tprsa_pkg::req_t                   req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output tprsa_pkg::rsp_t                   rsp_data,
    input  logic                              cfg_we,
    input  logic [tprsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tprsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tprsa_pkg::*;

    ctl_cmd_t ctl_cmd;
    ctl_sts_t ctl_sts;

    // Result qualifiers for the checks below
    logic rsp_grant;
    logic rsp_nogrant;
    logic rsp_id_clear;

    // Sequencer
    tprsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (ctl_sts),
        .cmd       (ctl_cmd)
    );

    // Datapath
    tprsa_datapath
    #(
        .SMALL_DEPTH (SMALL_DEPTH),
        .LARGE_DEPTH (LARGE_DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .cmd       (ctl_cmd),
        .sts       (ctl_sts)
    );

    // New transactions only while the sequencer is idle
    assign req_stall = !ctl_cmd.idle;

    assign rsp_grant    = rsp_valid && (rsp_data.status == ST_GRANTED);
    assign rsp_nogrant  = rsp_valid && (rsp_data.status != ST_GRANTED);
    assign rsp_id_clear = (rsp_data.granted_pool == 1'b0) && (rsp_data.granted_slot == '0);

    // One transaction in flight: an accepted request blocks the next cycle
    `TPRSA_ASSERT_NEXT(a_single_inflight, clk, rst_n, req_valid && !req_stall, req_stall)

    // A result without a grant carries pool and slot zero
    `TPRSA_ASSERT_IMPL(a_nogrant_zero, clk, rst_n, rsp_nogrant, rsp_id_clear)

    // A grant leaves at least one slot counted as in use
    `TPRSA_ASSERT_IMPL(a_grant_counted, clk, rst_n, rsp_grant, rsp_data.slots_in_use != '0)

endmodule
